// ===== rtl/core/wcd_pkg.sv =====
`timescale 1ns / 1ps

package wcd_pkg;

    // Sample and result formats
    localparam int SAMPLE_WIDTH = 16;
    localparam int RES_W        = 32;

    // Window geometry
    localparam int MAX_ORDER  = 16;
    localparam int WIN_DEPTH  = 2 * MAX_ORDER + 1;
    localparam int RING_AW    = $clog2(WIN_DEPTH);
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam int RING_SLACK = RING_DEPTH - WIN_DEPTH;

    // Widths of counters and distances
    localparam int KW          = $clog2(MAX_ORDER + 1);
    localparam int DW          = $clog2(WIN_DEPTH);
    localparam int FW          = $clog2(WIN_DEPTH + 1);
    localparam int ORDER_W     = 5;
    localparam int ORDER_RESET = 1;
    localparam int CNT_W       = 6;
    localparam int CNT_MAX     = 63;

    // Datapath widths
    localparam int COEFF_W = 16;
    localparam int SUM_W   = SAMPLE_WIDTH + 2 + KW;
    localparam int PROD_W  = SUM_W + COEFF_W + 1;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last;
    } in_item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] derivative;
        logic                    last_res;
    } out_item_t;

    // One result to compute, as handed from front to back
    typedef struct packed {
        logic [RING_AW-1:0]             head;
        logic [FW-1:0]                  fill;
        logic [KW-1:0]                  center;
        logic [KW-1:0]                  order;
        logic [CNT_W-1:0]               emitted;
        logic signed [SAMPLE_WIDTH-1:0] first;
        logic                           last;
    } cmd_t;

    typedef struct packed {
        logic                           en;
        logic [RING_AW-1:0]             addr;
        logic signed [SAMPLE_WIDTH-1:0] data;
    } wr_t;

    // Oldest window snapshot still being read
    typedef struct packed {
        logic               valid;
        logic [RING_AW-1:0] head;
    } oldest_t;

    typedef struct packed {
        logic               busy;
        logic [RING_AW-1:0] head;
    } back_stat_t;

    typedef enum logic {
        F_IDLE,
        F_ISSUE
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_LAST,
        B_MUL,
        B_OUT
    } back_state_t;

    // Q0.16 coefficient: round(65536 / (k * (k + 1)))
    function automatic logic [COEFF_W-1:0] coeff_q16(input logic [KW-1:0] k);
        logic [COEFF_W-1:0] c;
        begin
            case (int'(k))
                1:       c = 16'd32768;
                2:       c = 16'd10923;
                3:       c = 16'd5461;
                4:       c = 16'd3277;
                5:       c = 16'd2185;
                6:       c = 16'd1560;
                7:       c = 16'd1170;
                8:       c = 16'd910;
                9:       c = 16'd728;
                10:      c = 16'd596;
                11:      c = 16'd496;
                12:      c = 16'd420;
                13:      c = 16'd360;
                14:      c = 16'd312;
                15:      c = 16'd273;
                16:      c = 16'd241;
                17:      c = 16'd214;
                18:      c = 16'd192;
                19:      c = 16'd172;
                20:      c = 16'd156;
                21:      c = 16'd142;
                22:      c = 16'd130;
                23:      c = 16'd119;
                24:      c = 16'd109;
                25:      c = 16'd101;
                26:      c = 16'd93;
                27:      c = 16'd87;
                28:      c = 16'd81;
                29:      c = 16'd75;
                30:      c = 16'd70;
                31:      c = 16'd66;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== rtl/core/wcd_front.sv =====
`timescale 1ns / 1ps

module wcd_front import wcd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ORDER_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    input  oldest_t            oldest,
    output wr_t                wr,
    output logic               q_push,
    output cmd_t               q_data,
    input  logic               q_full
);

    front_state_t              state_reg, state_next;
    logic [ORDER_W-1:0]        order_reg;
    logic [CNT_W-1:0]          seen_reg, seen_next;
    logic [CNT_W-1:0]          emitted_reg, emitted_next;
    logic signed [SAMPLE_WIDTH-1:0] first_reg, first_next;
    logic [RING_AW-1:0]        wp_reg, wp_next;
    logic [RING_AW-1:0]        head_reg, head_next;
    logic [FW-1:0]             fill_reg, fill_next;
    logic                      emit_now_reg, emit_now_next;
    logic [KW-1:0]             pend_reg, pend_next;
    logic                      last_reg, last_next;

    logic [KW-1:0]             k;
    logic [CNT_W-1:0]          seen_inc;
    logic [RING_AW-1:0]        gap;
    logic                      room;
    logic                      issue_done;

    // Clamp the order into 1..MAX_ORDER
    always_comb begin
        if (order_reg == '0) begin
            k = KW'(1);
        end else if (order_reg > ORDER_W'(MAX_ORDER)) begin
            k = KW'(MAX_ORDER);
        end else begin
            k = KW'(order_reg);
        end
    end

    // Hold off a write that would overrun a window snapshot still in use
    assign gap       = wp_reg - oldest.head;
    assign room      = !oldest.valid || (gap <= RING_AW'(RING_SLACK));
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == F_IDLE) && room;

    assign seen_inc = (seen_reg == CNT_W'(CNT_MAX)) ? seen_reg : seen_reg + CNT_W'(1);

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_W'(ORDER_RESET);
        end else if (cfg_valid && cfg_ready) begin
            order_reg <= cfg_data;
        end
    end

    // Accept a sample, then issue its results one command at a time
    always_comb begin
        state_next    = state_reg;
        seen_next     = seen_reg;
        emitted_next  = emitted_reg;
        first_next    = first_reg;
        wp_next       = wp_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        emit_now_next = emit_now_reg;
        pend_next     = pend_reg;
        last_next     = last_reg;
        issue_done    = 1'b0;
        wr            = '0;
        q_push        = 1'b0;
        q_data        = '0;
        q_data.head    = head_reg;
        q_data.fill    = fill_reg;
        q_data.order   = k;
        q_data.emitted = emitted_reg;
        q_data.first   = first_reg;

        case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    wr.en   = 1'b1;
                    wr.addr = wp_reg;
                    wr.data = s_data.sample;
                    seen_next = seen_inc;
                    if (seen_reg == '0) begin
                        first_next = s_data.sample;
                    end
                    wp_next   = wp_reg + RING_AW'(1);
                    head_next = wp_reg;
                    if (fill_reg != FW'(WIN_DEPTH)) begin
                        fill_next = fill_reg + FW'(1);
                    end
                    emit_now_next = seen_inc > CNT_W'(k);
                    if (s_data.last) begin
                        pend_next = (seen_inc < CNT_W'(k)) ? KW'(seen_inc) : k;
                    end else begin
                        pend_next = '0;
                    end
                    last_next = s_data.last;
                    if ((seen_inc > CNT_W'(k)) || s_data.last) begin
                        state_next = F_ISSUE;
                    end
                end
            end
            F_ISSUE: begin
                if (!q_full) begin
                    q_push = 1'b1;
                    if (emitted_reg != CNT_W'(CNT_MAX)) begin
                        emitted_next = emitted_reg + CNT_W'(1);
                    end
                    if (emit_now_reg) begin
                        q_data.center = k;
                        q_data.last   = 1'b0;
                        emit_now_next = 1'b0;
                        issue_done    = (pend_reg == '0);
                    end else begin
                        q_data.center = pend_reg - KW'(1);
                        q_data.last   = (pend_reg == KW'(1));
                        pend_next     = pend_reg - KW'(1);
                        issue_done    = (pend_reg == KW'(1));
                    end
                    if (issue_done) begin
                        state_next = F_IDLE;
                        // Start a new record after the flush
                        if (last_reg) begin
                            seen_next    = '0;
                            emitted_next = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            seen_reg     <= '0;
            emitted_reg  <= '0;
            first_reg    <= '0;
            wp_reg       <= '0;
            head_reg     <= '0;
            fill_reg     <= '0;
            emit_now_reg <= 1'b0;
            pend_reg     <= '0;
            last_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            emitted_reg  <= emitted_next;
            first_reg    <= first_next;
            wp_reg       <= wp_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            emit_now_reg <= emit_now_next;
            pend_reg     <= pend_next;
            last_reg     <= last_next;
        end
    end

endmodule

// ===== rtl/core/wcd_queue.sv =====
`timescale 1ns / 1ps

module wcd_queue import wcd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign data    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Store an entry on push
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/wcd_back.sv =====
`timescale 1ns / 1ps

module wcd_back import wcd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  wr_t        wr,
    input  logic       q_valid,
    input  cmd_t       q_data,
    output logic       q_pop,
    output back_stat_t stat,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    logic signed [SAMPLE_WIDTH-1:0] mem [RING_DEPTH];

    back_state_t              state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [KW-1:0]            j_reg, j_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg, m_data_next;

    logic signed [SAMPLE_WIDTH-1:0] rd_r_reg, rd_l_reg;
    logic                     vr_reg, vl_reg, uf_reg, acc_reg;

    logic [DW-1:0]            dr, dl;
    logic [RING_AW-1:0]       addr_r, addr_l;
    logic signed [SUM_W-1:0]  right, left;
    logic [COEFF_W-1:0]       coeff;
    logic [PROD_W-RES_W:0]    hi;
    logic signed [RES_W-1:0]  res;

    // Window ring: written by the front, read at two taps here
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Tap distances for step j, clamped at the newest sample
    assign dr     = (cmd_reg.center >= j_reg) ? DW'(cmd_reg.center - j_reg) : '0;
    assign dl     = DW'(cmd_reg.center) + DW'(j_reg);
    assign addr_r = cmd_reg.head - RING_AW'(dr);
    assign addr_l = cmd_reg.head - RING_AW'(dl);

    // Register read data and per-step selects
    always_ff @(posedge aclk) begin
        rd_r_reg <= mem[addr_r];
        rd_l_reg <= mem[addr_l];
        vr_reg   <= FW'(dr) < cmd_reg.fill;
        vl_reg   <= FW'(dl) < cmd_reg.fill;
        uf_reg   <= cmd_reg.emitted < CNT_W'(j_reg);
    end

    // Entries never written read as zero; early left taps use the first sample
    assign right = vr_reg ? SUM_W'(rd_r_reg) : '0;
    assign left  = uf_reg ? SUM_W'(cmd_reg.first) : (vl_reg ? SUM_W'(rd_l_reg) : '0);
    assign coeff = coeff_q16(cmd_reg.order);

    // Saturate the product to 32 bits
    always_comb begin
        hi = prod_reg[PROD_W-1:RES_W-1];
        if ((&hi) || !(|hi)) begin
            res = prod_reg[RES_W-1:0];
        end else if (prod_reg[PROD_W-1]) begin
            res = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(RES_W-1){1'b1}}};
        end
    end

    // Sequence one result: pop, k read steps, a final accumulate, multiply, load the output register
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        j_next       = j_reg;
        sum_next     = acc_reg ? (sum_reg + right - left) : sum_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;

        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    j_next     = KW'(1);
                    sum_next   = '0;
                    state_next = B_READ;
                end
            end
            B_READ: begin
                if (j_reg == cmd_reg.order) begin
                    state_next = B_LAST;
                end else begin
                    j_next = j_reg + KW'(1);
                end
            end
            B_LAST: begin
                state_next = B_MUL;
            end
            B_MUL: begin
                prod_next  = PROD_W'(sum_reg) * PROD_W'($signed({1'b0, coeff}));
                state_next = B_OUT;
            end
            B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.derivative = res;
                    m_data_next.last_res   = cmd_reg.last;
                    state_next           = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= (state_reg == B_READ);
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        j_reg      <= j_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign stat.busy = (state_reg == B_READ);
    assign stat.head = cmd_reg.head;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

// ===== rtl/core/windowed_central_difference.sv =====
`timescale 1ns / 1ps

// Smoothed central-difference derivative over records of signed samples.
// s_ channel: one sample per transfer, last marks the end of a record.
// m_ channel: one Q15.16 derivative per transfer, last_res on the final one.
// cfg channel: writes the half window K (0 acts as 1, above 16 acts as 16);
//   write it only while no results are outstanding.
// Result i leaves after sample i+K is taken; the last sample flushes the
// rest of the record in index order.
// In the back end each result takes one queue pop, K read steps over the
// two-tap window ring, one accumulate, one multiply and one output load,
// and the back end takes no new command until that result is loaded into
// the output register, which waits while the receiver stalls it.
// The front end takes samples and queues result commands, one per cycle;
// it drops s_ready while it queues them, also while it waits on a full command
// queue, and while the next write would overrun the window still being read.
// A stalled receiver backs up the output register, then the back end, then
// the queue, then s_ready.
// Reset empties the queue and the output register, sets K to 1 and
// starts a new record with a zeroed window.
module windowed_central_difference import wcd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ORDER_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data
);

    wr_t        wr;
    logic       q_push, q_full, q_pop, q_valid;
    cmd_t       q_in, q_out;
    back_stat_t stat;
    oldest_t    oldest;

    // Oldest snapshot in use: the active command, else the queue head
    always_comb begin
        if (stat.busy) begin
            oldest.valid = 1'b1;
            oldest.head  = stat.head;
        end else begin
            oldest.valid = q_valid;
            oldest.head  = q_out.head;
        end
    end

    wcd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .oldest    (oldest),
        .wr        (wr),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    wcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_out)
    );

    wcd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTH
    // Never push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // Never pop an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("command popped from empty queue");

    // A window write stays clear of the snapshot still being read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && oldest.valid) |->
            ((RING_AW'(wr.addr - oldest.head) != '0) &&
             (RING_AW'(wr.addr - oldest.head) <= RING_AW'(RING_SLACK))))
        else $error("window write overruns a live snapshot");

    // The active command keeps its snapshot while reading
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.busy && $past(stat.busy) && !$past(q_pop)) |-> $stable(stat.head))
        else $error("snapshot head changed during read steps");
`endif

endmodule
